// File: hw/rtl/nsm_pkg.sv
// Shared types and codes for the stack machine token executor.
package nsm_pkg;

  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_SKIP   = 3'd1;
  localparam logic [2:0] STS_OVER   = 3'd2;
  localparam logic [2:0] STS_UNDER  = 3'd3;
  localparam logic [2:0] STS_BADIDX = 3'd4;
  localparam logic [2:0] STS_HALT   = 3'd5;

  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned DEPTH_W = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [3:0] {
    ACT_PUSH     = 4'd0,
    ACT_REGSTORE = 4'd1,
    ACT_REGGET   = 4'd2,
    ACT_XREGGET  = 4'd3,
    ACT_POP      = 4'd4,
    ACT_XPOP     = 4'd5,
    ACT_NAND     = 4'd6,
    ACT_XNAND    = 4'd7,
    ACT_COND     = 4'd8,
    ACT_XCOND    = 4'd9,
    ACT_HEAPSWAP = 4'd10,
    ACT_NOP      = 4'd11
  } act_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDN, S_GETN, S_CHK, S_RDX, S_RDY, S_GETX, S_GETY,
    S_EXE, S_RDT, S_GETT, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_NEXT, RD_X, RD_Y, RD_TOP
  } rd_sel_t;

  typedef struct packed {
    logic    clr_en;
    logic    load;
    rd_sel_t rd_sel;
    logic    cap_nx;
    logic    cap_wx;
    logic    cap_wy;
    logic    cap_top;
    logic    heap_rd;
    logic    check;
    logic    exec;
    logic    out_valid;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic halted;
    logic err;
    logic need_x;
    logic need_y;
    logic reload;
  } sts_t;

endpackage

// File: hw/rtl/nand_stack_machine_token_executor_top.sv
// Top level of the stack machine token executor.
// For a halted block, out_valid comes in the cycle after the accepting edge.
// A new request waits until busy drops; the single stack memory port serializes the reads.
// Reset: synchronous, active low; afterward busy stays high while the heap is cleared
// one byte a cycle. Results cannot be stalled.
module nand_stack_machine_token_executor_top #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned REG_COUNT   = 16,
  parameter int unsigned HEAP_BYTES  = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_action,
  input  logic [63:0]                 in_literal,
  input  logic [63:0]                 in_arg_a,
  input  logic [63:0]                 in_arg_b,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [10:0]                 out_stack_depth,
  output logic [63:0]                 out_top_word,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [12:0]                 cfg_data
);

  nsm_pkg::cmd_t cmd;
  nsm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;
  assign out_valid = cmd.out_valid;

  nsm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  nsm_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .REG_COUNT   (REG_COUNT),
    .HEAP_BYTES  (HEAP_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_literal      (in_literal),
    .in_arg_a        (in_arg_a),
    .in_arg_b        (in_arg_b),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_data),
    .out_status      (out_status),
    .out_stack_depth (out_stack_depth),
    .out_top_word    (out_top_word)
  );

endmodule

// File: hw/rtl/nsm_ctrl.sv
// Controller state machine sequencing each request through the datapath.
module nsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  nsm_pkg::sts_t sts,
  output nsm_pkg::cmd_t cmd,
  output logic          busy
);

  nsm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nsm_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != nsm_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rd_sel = nsm_pkg::RD_NONE;
    unique case (state_r)
      nsm_pkg::S_CLR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = nsm_pkg::S_IDLE;
      end
      nsm_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = sts.halted ? nsm_pkg::S_FIN : nsm_pkg::S_RDN;
        end
      end
      nsm_pkg::S_RDN: begin
        cmd.rd_sel = nsm_pkg::RD_NEXT;
        state_nxt = nsm_pkg::S_GETN;
      end
      nsm_pkg::S_GETN: begin
        cmd.cap_nx = 1'b1;
        state_nxt = nsm_pkg::S_CHK;
      end
      nsm_pkg::S_CHK: begin
        cmd.check = 1'b1;
        if (sts.err) state_nxt = nsm_pkg::S_FIN;
        else if (sts.need_x) state_nxt = nsm_pkg::S_RDX;
        else state_nxt = nsm_pkg::S_EXE;
      end
      nsm_pkg::S_RDX: begin
        cmd.rd_sel = nsm_pkg::RD_X;
        state_nxt = sts.need_y ? nsm_pkg::S_RDY : nsm_pkg::S_GETX;
      end
      nsm_pkg::S_RDY: begin
        cmd.cap_wx = 1'b1;
        cmd.rd_sel = nsm_pkg::RD_Y;
        state_nxt = nsm_pkg::S_GETY;
      end
      nsm_pkg::S_GETX: begin
        cmd.cap_wx = 1'b1;
        state_nxt = nsm_pkg::S_EXE;
      end
      nsm_pkg::S_GETY: begin
        cmd.cap_wy = 1'b1;
        cmd.heap_rd = 1'b1;
        state_nxt = nsm_pkg::S_EXE;
      end
      nsm_pkg::S_EXE: begin
        cmd.exec = 1'b1;
        state_nxt = nsm_pkg::S_RDT;
      end
      nsm_pkg::S_RDT: begin
        if (sts.reload) begin
          cmd.rd_sel = nsm_pkg::RD_TOP;
          state_nxt = nsm_pkg::S_GETT;
        end else begin
          state_nxt = nsm_pkg::S_FIN;
        end
      end
      nsm_pkg::S_GETT: begin
        cmd.cap_top = 1'b1;
        state_nxt = nsm_pkg::S_FIN;
      end
      nsm_pkg::S_FIN: begin
        cmd.out_valid = 1'b1;
        state_nxt = nsm_pkg::S_IDLE;
      end
      default: state_nxt = nsm_pkg::S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/nsm_dp.sv
// Datapath: stack memory, register file, heap memory, checks and execution.
module nsm_dp #(
  parameter int unsigned STACK_DEPTH = 1024,
  parameter int unsigned REG_COUNT   = 16,
  parameter int unsigned HEAP_BYTES  = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nsm_pkg::cmd_t                   cmd,
  output nsm_pkg::sts_t                   sts,
  input  logic [3:0]                      in_action,
  input  logic [63:0]                     in_literal,
  input  logic [63:0]                     in_arg_a,
  input  logic [63:0]                     in_arg_b,
  input  logic                            cfg_we,
  input  logic [nsm_pkg::LIMIT_W-1:0]     cfg_data,
  output logic [2:0]                      out_status,
  output logic [nsm_pkg::DEPTH_W-1:0]     out_stack_depth,
  output logic [63:0]                     out_top_word
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned HW = $clog2(HEAP_BYTES);

  logic [63:0] stk_mem [STACK_DEPTH];
  logic [7:0]  heap_mem [HEAP_BYTES];
  logic [63:0] regs_r [REG_COUNT];

  nsm_pkg::act_t          act_r;
  logic [63:0]            lit_r, a_r, b_r, nx_r, wx_r, wy_r, top_r, stk_q;
  logic [7:0]             heap_q;
  logic [AW-1:0]          cnt_r, cnt_nxt;
  logic                   halted_r, reload_r;
  logic [2:0]             status_r;
  logic [nsm_pkg::LIMIT_W-1:0] limit_r;
  logic [HW-1:0]          clr_r;

  logic [63:0] cnt64, ix, iy;
  logic [2:0]  chk_code;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        rd_en, stk_we, heap_we, reg_we, heap_bad, top_we;
  logic [63:0] wr_data, reg_rd, top_val;
  logic [2:0]  ex_code;

  assign cnt64 = 64'(cnt_r);

  always_comb begin
    ix = top_r;
    iy = nx_r;
    case (act_r)
      nsm_pkg::ACT_REGSTORE: ix = nx_r;
      nsm_pkg::ACT_XNAND: begin
        ix = b_r - 64'd2;
        iy = a_r - 64'd2;
      end
      nsm_pkg::ACT_XCOND: ix = lit_r - 64'd1;
      default: ;
    endcase
  end

  always_comb begin
    chk_code = nsm_pkg::STS_OK;
    case (act_r) inside
      nsm_pkg::ACT_PUSH:
        if (cnt_r >= AW'(STACK_DEPTH - 1)) chk_code = nsm_pkg::STS_OVER;
      nsm_pkg::ACT_XREGGET:
        if (lit_r >= 64'(REG_COUNT)) chk_code = nsm_pkg::STS_BADIDX;
        else if (cnt_r >= AW'(STACK_DEPTH - 1)) chk_code = nsm_pkg::STS_OVER;
      nsm_pkg::ACT_REGSTORE:
        if (cnt64 < 64'd2) chk_code = nsm_pkg::STS_UNDER;
        else if (nx_r >= cnt64 || top_r >= 64'(REG_COUNT)) chk_code = nsm_pkg::STS_BADIDX;
      nsm_pkg::ACT_REGGET:
        if (cnt64 == 64'd0) chk_code = nsm_pkg::STS_UNDER;
        else if (top_r >= 64'(REG_COUNT)) chk_code = nsm_pkg::STS_BADIDX;
      nsm_pkg::ACT_POP:
        if (cnt64 == 64'd0 || top_r > cnt64 - 64'd1) chk_code = nsm_pkg::STS_UNDER;
      nsm_pkg::ACT_XPOP:
        if (lit_r > cnt64) chk_code = nsm_pkg::STS_UNDER;
      nsm_pkg::ACT_NAND, nsm_pkg::ACT_HEAPSWAP:
        if (cnt64 < 64'd2) chk_code = nsm_pkg::STS_UNDER;
        else if (ix >= cnt64 || iy >= cnt64) chk_code = nsm_pkg::STS_BADIDX;
      nsm_pkg::ACT_XNAND:
        if (ix >= cnt64 || iy >= cnt64) chk_code = nsm_pkg::STS_BADIDX;
      nsm_pkg::ACT_COND:
        if (cnt64 == 64'd0) chk_code = nsm_pkg::STS_UNDER;
        else if (ix >= cnt64) chk_code = nsm_pkg::STS_BADIDX;
      nsm_pkg::ACT_XCOND:
        if (lit_r != 64'd0 && ix >= cnt64) chk_code = nsm_pkg::STS_BADIDX;
      default: ;
    endcase
  end

  assign sts.clr_last = (clr_r == HW'(HEAP_BYTES - 1));
  assign sts.halted   = halted_r;
  assign sts.err      = (chk_code != nsm_pkg::STS_OK);
  assign sts.need_x   = (act_r == nsm_pkg::ACT_REGSTORE) || (act_r == nsm_pkg::ACT_NAND) ||
                        (act_r == nsm_pkg::ACT_XNAND) || (act_r == nsm_pkg::ACT_COND) ||
                        (act_r == nsm_pkg::ACT_HEAPSWAP) ||
                        (act_r == nsm_pkg::ACT_XCOND && lit_r != 64'd0);
  assign sts.need_y   = (act_r == nsm_pkg::ACT_NAND) || (act_r == nsm_pkg::ACT_XNAND) ||
                        (act_r == nsm_pkg::ACT_HEAPSWAP);
  assign sts.reload   = reload_r;

  always_comb begin
    rd_en = 1'b1;
    case (cmd.rd_sel)
      nsm_pkg::RD_NEXT: rd_addr = cnt_r - AW'(2);
      nsm_pkg::RD_X:    rd_addr = cnt_r - AW'(1) - ix[AW-1:0];
      nsm_pkg::RD_Y:    rd_addr = cnt_r - AW'(1) - iy[AW-1:0];
      nsm_pkg::RD_TOP:  rd_addr = cnt_r - AW'(1);
      default: begin
        rd_addr = cnt_r;
        rd_en = 1'b0;
      end
    endcase
  end

  assign heap_bad = (wx_r >= 64'(limit_r)) || (wx_r >= 64'(HEAP_BYTES));

  always_comb begin
    reg_rd  = (act_r == nsm_pkg::ACT_XREGGET) ? regs_r[lit_r[RW-1:0]] : regs_r[top_r[RW-1:0]];
    stk_we  = 1'b0;
    heap_we = 1'b0;
    reg_we  = 1'b0;
    top_we  = 1'b0;
    top_val = 64'd0;
    wr_addr = cnt_r;
    wr_data = 64'd0;
    cnt_nxt = cnt_r;
    ex_code = nsm_pkg::STS_OK;
    case (act_r) inside
      nsm_pkg::ACT_PUSH, nsm_pkg::ACT_XREGGET: begin
        stk_we  = 1'b1;
        wr_data = (act_r == nsm_pkg::ACT_PUSH) ? lit_r : reg_rd;
        top_we  = 1'b1;
        top_val = wr_data;
        cnt_nxt = cnt_r + AW'(1);
      end
      nsm_pkg::ACT_REGSTORE: begin
        reg_we  = 1'b1;
        cnt_nxt = cnt_r - AW'(2);
      end
      nsm_pkg::ACT_REGGET: begin
        stk_we  = 1'b1;
        wr_addr = cnt_r - AW'(1);
        wr_data = reg_rd;
        top_we  = 1'b1;
        top_val = reg_rd;
      end
      nsm_pkg::ACT_POP:  cnt_nxt = cnt_r - AW'(1) - top_r[AW-1:0];
      nsm_pkg::ACT_XPOP: cnt_nxt = cnt_r - lit_r[AW-1:0];
      nsm_pkg::ACT_NAND, nsm_pkg::ACT_XNAND: begin
        stk_we  = 1'b1;
        wr_addr = cnt_r - AW'(1) - iy[AW-1:0];
        wr_data = ~(wx_r & wy_r);
        if (act_r == nsm_pkg::ACT_NAND) begin
          cnt_nxt = cnt_r - AW'(2);
        end else if (iy == 64'd0) begin
          top_we  = 1'b1;
          top_val = wr_data;
        end
      end
      nsm_pkg::ACT_COND: begin
        cnt_nxt = cnt_r - AW'(1);
        if (wx_r == 64'd0) ex_code = nsm_pkg::STS_SKIP;
      end
      nsm_pkg::ACT_XCOND:
        if (lit_r == 64'd0 || wx_r == 64'd0) ex_code = nsm_pkg::STS_SKIP;
      nsm_pkg::ACT_HEAPSWAP: begin
        if (heap_bad) begin
          ex_code = nsm_pkg::STS_BADIDX;
        end else begin
          heap_we = 1'b1;
          stk_we  = 1'b1;
          wr_addr = cnt_r - AW'(1) - iy[AW-1:0];
          wr_data = {{56{heap_q[7]}}, heap_q};
          cnt_nxt = cnt_r - AW'(2);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && stk_we) stk_mem[wr_addr] <= wr_data;
    if (rd_en) stk_q <= stk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) heap_mem[clr_r] <= 8'd0;
    else if (cmd.exec && heap_we) heap_mem[wx_r[HW-1:0]] <= wy_r[7:0];
    if (cmd.heap_rd) heap_q <= heap_mem[wx_r[HW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(REG_COUNT); i++) regs_r[i] <= 64'd0;
    end else if (cmd.exec && reg_we) begin
      regs_r[top_r[RW-1:0]] <= wx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= nsm_pkg::act_t'(in_action);
      lit_r <= in_literal;
      a_r   <= in_arg_a;
      b_r   <= in_arg_b;
    end
    if (cmd.cap_nx) nx_r <= stk_q;
    if (cmd.cap_wx) wx_r <= stk_q;
    if (cmd.cap_wy) wy_r <= stk_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      top_r    <= 64'd0;
      halted_r <= 1'b0;
      reload_r <= 1'b0;
      status_r <= nsm_pkg::STS_OK;
      limit_r  <= nsm_pkg::LIMIT_RESET;
      clr_r    <= '0;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      if (cmd.clr_en && !sts.clr_last) clr_r <= clr_r + HW'(1);
      if (cmd.load) begin
        status_r <= halted_r ? nsm_pkg::STS_HALT : nsm_pkg::STS_OK;
        reload_r <= 1'b0;
      end
      if (cmd.check && sts.err) begin
        status_r <= chk_code;
        halted_r <= 1'b1;
      end
      if (cmd.exec) begin
        status_r <= ex_code;
        if (ex_code == nsm_pkg::STS_BADIDX) begin
          halted_r <= 1'b1;
        end else begin
          cnt_r <= cnt_nxt;
          if (top_we) top_r <= top_val;
          else if (cnt_nxt < cnt_r) begin
            if (cnt_nxt == '0) top_r <= 64'd0;
            else reload_r <= 1'b1;
          end
        end
      end
      if (cmd.cap_top) top_r <= stk_q;
    end
  end

  assign out_status      = status_r;
  assign out_stack_depth = nsm_pkg::DEPTH_W'(cnt_r);
  assign out_top_word    = top_r;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stack machine token executor.
module testbench;

  localparam int STK_N = 1024;
  localparam int REG_N = 16;
  localparam int HEAP_N = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    logic [2:0]  status;
    logic [10:0] depth;
    logic [63:0] top;
  } token_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_action = '0;
  logic [63:0] in_literal = '0;
  logic [63:0] in_arg_a = '0;
  logic [63:0] in_arg_b = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [10:0] out_stack_depth;
  logic [63:0] out_top_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [12:0] cfg_data = '0;

  nand_stack_machine_token_executor_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_literal(in_literal), .in_arg_a(in_arg_a),
    .in_arg_b(in_arg_b), .out_valid(out_valid), .out_status(out_status),
    .out_stack_depth(out_stack_depth), .out_top_word(out_top_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the block state
  logic [63:0] stk_mem [STK_N];
  int unsigned stk_cnt;
  logic [63:0] reg_mem [REG_N];
  logic [7:0] heap_mem [HEAP_N];
  bit halted;
  int unsigned heap_lim;

  token_result_t pending_results[$];
  int sent_cnt, checked_cnt, mismatch_cnt, skip_cnt, swap_cnt, cycle_cnt;
  bit idle_on;

  function automatic logic [63:0] peek(logic [63:0] pos);
    return stk_mem[stk_cnt - 1 - int'(pos)];
  endfunction

  function automatic token_result_t exec_token(logic [3:0] act, logic [63:0] lit,
                                               logic [63:0] a, logic [63:0] b);
    token_result_t r;
    logic [2:0] st;
    logic [63:0] c, p, q, f, s, v, addr;
    c = 64'(stk_cnt);
    st = nsm_pkg::STS_OK;
    if (halted) begin
      st = nsm_pkg::STS_HALT;
    end else begin
      case (act) inside
        nsm_pkg::ACT_PUSH: begin
          if (stk_cnt >= STK_N - 1) st = nsm_pkg::STS_OVER;
          else begin
            stk_mem[stk_cnt] = lit;
            stk_cnt++;
          end
        end
        nsm_pkg::ACT_REGSTORE: begin
          if (c < 2) st = nsm_pkg::STS_UNDER;
          else begin
            q = peek(0);
            p = peek(1);
            if (p >= c || q >= REG_N) st = nsm_pkg::STS_BADIDX;
            else begin
              reg_mem[int'(q)] = peek(p);
              stk_cnt -= 2;
            end
          end
        end
        nsm_pkg::ACT_REGGET: begin
          if (c < 1) st = nsm_pkg::STS_UNDER;
          else begin
            q = peek(0);
            if (q >= REG_N) st = nsm_pkg::STS_BADIDX;
            else stk_mem[stk_cnt - 1] = reg_mem[int'(q)];
          end
        end
        nsm_pkg::ACT_XREGGET: begin
          if (lit >= REG_N) st = nsm_pkg::STS_BADIDX;
          else if (stk_cnt >= STK_N - 1) st = nsm_pkg::STS_OVER;
          else begin
            stk_mem[stk_cnt] = reg_mem[int'(lit)];
            stk_cnt++;
          end
        end
        nsm_pkg::ACT_POP: begin
          if (c < 1) st = nsm_pkg::STS_UNDER;
          else begin
            v = peek(0);
            if (v > c - 1) st = nsm_pkg::STS_UNDER;
            else stk_cnt = int'(c - 1 - v);
          end
        end
        nsm_pkg::ACT_XPOP: begin
          if (lit > c) st = nsm_pkg::STS_UNDER;
          else stk_cnt = int'(c - lit);
        end
        nsm_pkg::ACT_NAND, nsm_pkg::ACT_XNAND: begin
          if (act == nsm_pkg::ACT_NAND && c < 2) st = nsm_pkg::STS_UNDER;
          else begin
            if (act == nsm_pkg::ACT_NAND) begin
              f = peek(0);
              s = peek(1);
            end else begin
              f = b - 2;
              s = a - 2;
            end
            if (f >= c || s >= c) st = nsm_pkg::STS_BADIDX;
            else begin
              stk_mem[stk_cnt - 1 - int'(s)] = ~(peek(f) & peek(s));
              if (act == nsm_pkg::ACT_NAND) stk_cnt -= 2;
            end
          end
        end
        nsm_pkg::ACT_COND: begin
          if (c < 1) st = nsm_pkg::STS_UNDER;
          else begin
            p = peek(0);
            if (p >= c) st = nsm_pkg::STS_BADIDX;
            else begin
              v = peek(p);
              stk_cnt -= 1;
              st = (v != 0) ? nsm_pkg::STS_OK : nsm_pkg::STS_SKIP;
            end
          end
        end
        nsm_pkg::ACT_XCOND: begin
          if (lit == 0) st = nsm_pkg::STS_SKIP;
          else if (lit - 1 >= c) st = nsm_pkg::STS_BADIDX;
          else st = (peek(lit - 1) != 0) ? nsm_pkg::STS_OK : nsm_pkg::STS_SKIP;
        end
        nsm_pkg::ACT_HEAPSWAP: begin
          if (c < 2) st = nsm_pkg::STS_UNDER;
          else begin
            p = peek(0);
            q = peek(1);
            if (p >= c || q >= c) st = nsm_pkg::STS_BADIDX;
            else begin
              addr = peek(p);
              if (addr >= heap_lim || addr >= HEAP_N) st = nsm_pkg::STS_BADIDX;
              else begin
                v = {{56{heap_mem[int'(addr)][7]}}, heap_mem[int'(addr)]};
                s = peek(q);
                heap_mem[int'(addr)] = s[7:0];
                stk_mem[stk_cnt - 1 - int'(q)] = v;
                stk_cnt -= 2;
              end
            end
          end
        end
        default: ;
      endcase
      if (st == nsm_pkg::STS_OVER || st == nsm_pkg::STS_UNDER || st == nsm_pkg::STS_BADIDX)
        halted = 1'b1;
    end
    r.status = st;
    r.depth = stk_cnt[10:0];
    r.top = (stk_cnt != 0) ? stk_mem[stk_cnt - 1] : 64'd0;
    return r;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return 64'($urandom_range(0, 255));
      default: return rnd64();
    endcase
  endfunction

  task automatic send(logic [3:0] act, logic [63:0] lit, logic [63:0] a, logic [63:0] b);
    in_action <= act;
    in_literal <= lit;
    in_arg_a <= a;
    in_arg_b <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(exec_token(act, lit, a, b));
    sent_cnt++;
  endtask

  task automatic send_lit(logic [3:0] act, logic [63:0] lit);
    send(act, lit, rnd64(), rnd64());
  endtask

  task automatic maybe_pause();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic write_limit(logic [12:0] val);
    drain();
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    heap_lim = val;
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned small_upto(int unsigned hi);
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, hi);
    return $urandom_range(0, (hi < 3) ? hi : 3);
  endfunction

  // one well-formed token sequence that never errs
  task automatic token_seq(int kind);
    int unsigned lim;
    if (stk_cnt > 600) begin
      send_lit(nsm_pkg::ACT_XPOP, 64'($urandom_range(300, stk_cnt)));
      return;
    end
    case (kind)
      0: send_lit(nsm_pkg::ACT_PUSH, pick_word());
      1: begin
        send_lit(nsm_pkg::ACT_PUSH, 64'($urandom_range(0, stk_cnt + 1)));
        send_lit(nsm_pkg::ACT_PUSH, 64'($urandom_range(0, REG_N - 1)));
        maybe_pause();
        send_lit(nsm_pkg::ACT_REGSTORE, rnd64());
      end
      2: begin
        send_lit(nsm_pkg::ACT_PUSH, 64'($urandom_range(0, REG_N - 1)));
        send_lit(nsm_pkg::ACT_REGGET, rnd64());
      end
      3: send_lit(nsm_pkg::ACT_XREGGET, 64'($urandom_range(0, REG_N - 1)));
      4: begin
        send_lit(nsm_pkg::ACT_PUSH, 64'(small_upto(stk_cnt)));
        send_lit(nsm_pkg::ACT_POP, rnd64());
      end
      5: send_lit(nsm_pkg::ACT_XPOP, 64'(small_upto(stk_cnt)));
      6: begin
        send_lit(nsm_pkg::ACT_PUSH, 64'($urandom_range(0, stk_cnt + 1)));
        send_lit(nsm_pkg::ACT_PUSH, 64'($urandom_range(0, stk_cnt)));
        maybe_pause();
        send_lit(nsm_pkg::ACT_NAND, rnd64());
      end
      7: begin
        if (stk_cnt == 0) send_lit(nsm_pkg::ACT_PUSH, pick_word());
        send(nsm_pkg::ACT_XNAND, rnd64(), 64'($urandom_range(0, stk_cnt - 1)) + 2,
             64'($urandom_range(0, stk_cnt - 1)) + 2);
      end
      8: begin
        send_lit(nsm_pkg::ACT_PUSH, 64'($urandom_range(0, stk_cnt)));
        send_lit(nsm_pkg::ACT_COND, rnd64());
      end
      9: send_lit(nsm_pkg::ACT_XCOND, ($urandom_range(0, 3) == 0) ? 64'd0 :
                  64'($urandom_range(0, stk_cnt)));
      10: begin
        lim = (heap_lim < HEAP_N) ? heap_lim : HEAP_N;
        if (lim == 0) begin
          send_lit(nsm_pkg::ACT_PUSH, pick_word());
        end else begin
          send_lit(nsm_pkg::ACT_PUSH, pick_word());
          send_lit(nsm_pkg::ACT_PUSH, 64'(($urandom_range(0, 3) == 0) ?
                                          $urandom_range(0, lim - 1) :
                                          $urandom_range(0, (lim < 32 ? lim : 32) - 1)));
          send_lit(nsm_pkg::ACT_PUSH, 64'd3);
          maybe_pause();
          send_lit(nsm_pkg::ACT_PUSH, 64'd2);
          send_lit(nsm_pkg::ACT_HEAPSWAP, rnd64());
        end
      end
      default: send_lit(4'($urandom_range(nsm_pkg::ACT_NOP, 15)), rnd64());
    endcase
    maybe_pause();
  endtask

  always @(posedge clk) begin
    token_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result status %0d", out_status);
      end else begin
        e = pending_results.pop_front();
        checked_cnt++;
        if (out_status == nsm_pkg::STS_SKIP) skip_cnt++;
        if (out_status !== e.status || out_stack_depth !== e.depth ||
            out_top_word !== e.top) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp st=%0d dep=%0d top=%h got st=%0d dep=%0d top=%h",
                     e.status, e.depth, e.top, out_status, out_stack_depth, out_top_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("nand_stack_machine_token_executor_top test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_lit(nsm_pkg::ACT_XPOP, 64'd0);
    send_lit(nsm_pkg::ACT_XCOND, 64'd0);
    send_lit(nsm_pkg::ACT_PUSH, 64'd0);
    send_lit(nsm_pkg::ACT_PUSH, '1);
    send_lit(nsm_pkg::ACT_PUSH, 64'h8000_0000_0000_0080);
    send_lit(nsm_pkg::ACT_XREGGET, 64'd15);
    send_lit(nsm_pkg::ACT_XCOND, 64'd1);
    send_lit(nsm_pkg::ACT_XCOND, 64'd4);
    send(nsm_pkg::ACT_XNAND, 64'd0, 64'd3, 64'd2);
    for (int k = 0; k <= 10; k++) token_seq(k);
    for (int k = 12; k <= 15; k++) send_lit(4'(k), '1);
    send_lit(nsm_pkg::ACT_XPOP, 64'(stk_cnt));
  endtask

  task automatic test_random(int n);
    int base;
    base = sent_cnt;
    while (sent_cnt - base < n) begin
      if ($urandom_range(0, 99) == 0) idle_on = !idle_on;
      token_seq($urandom_range(0, 11));
    end
  endtask

  task automatic test_heap_limits();
    write_limit(13'd0);
    test_random(150);
    write_limit(13'd1);
    test_random(150);
    write_limit(13'h1FFF);
    test_random(150);
    write_limit(13'($urandom_range(2, 4095)));
    test_random(150);
    write_limit(13'd4096);
  endtask

  task automatic test_error_halt(int kind);
    idle_on = 0;
    case (kind)
      0: begin
        while (stk_cnt < STK_N - 1) send_lit(nsm_pkg::ACT_PUSH, rnd64());
        send_lit(nsm_pkg::ACT_PUSH, '1);
      end
      1: send_lit(nsm_pkg::ACT_XPOP, 64'(stk_cnt) + 1);
      default: send_lit(nsm_pkg::ACT_XREGGET, '1 - 64'($urandom_range(0, 100)));
    endcase
    for (int k = 0; k < 4; k++) send_lit(4'($urandom_range(0, 15)), rnd64());
  endtask

  initial begin
    int err_kind;
    for (int k = 0; k < STK_N; k++) stk_mem[k] = '0;
    for (int k = 0; k < REG_N; k++) reg_mem[k] = '0;
    for (int k = 0; k < HEAP_N; k++) heap_mem[k] = '0;
    stk_cnt = 0;
    halted = 0;
    heap_lim = nsm_pkg::LIMIT_RESET;
    idle_on = 1;
    err_kind = $urandom_range(0, 2);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(RANDOM_ITEMS - 600);
    test_heap_limits();
    test_error_halt(err_kind);
    drain();
    $display("sent %0d requests, checked %0d results, %0d skips; heap limits 0/1/max/rand",
             sent_cnt, checked_cnt, skip_cnt);
    $display("final error kind %0d (0 overflow, 1 underflow, 2 bad index), halted after",
             err_kind);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("nand_stack_machine_token_executor_top test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_cnt, pending_results.size());
      $display("nand_stack_machine_token_executor_top test failed");
    end
    $finish;
  end

endmodule
